[design/histogram_rejection_sampler_assert.svh]
`ifndef HISTOGRAM_REJECTION_SAMPLER_ASSERT_SVH
`define HISTOGRAM_REJECTION_SAMPLER_ASSERT_SVH

// same-cycle implication
`define HRS_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("histogram sampler check failed");

// next-cycle implication
`define HRS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("histogram sampler check failed");

`endif

[design/hrs_pkg.sv]
package hrs_pkg;

  localparam int BIN_COUNT    = 64;
  localparam int COUNT_BITS   = 24;
  localparam int IDX_BITS     = 6;
  localparam int VALUE_BITS   = 32;
  localparam int FRAC_BITS    = 32;
  localparam int OFF_BITS     = VALUE_BITS + IDX_BITS;
  localparam int TOP_BITS     = OFF_BITS + 1;
  localparam int SPAN_HI_BITS = TOP_BITS - VALUE_BITS;
  localparam int HGT_BITS     = COUNT_BITS + FRAC_BITS;
  localparam int SWEEP_BITS   = $clog2(BIN_COUNT + 2);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = 1;
  localparam int CFG_IDX_BITS = 1;
  localparam int S_TDATA_BITS = 128;
  localparam int M_TDATA_BITS = 40;
  localparam int M_PAD_BITS   = M_TDATA_BITS - IDX_BITS - VALUE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_EDGE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_WIDTH  = 1'b1;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_DRAW = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [IDX_BITS-1:0]   idx;
    logic [COUNT_BITS-1:0] cnt;
    logic [VALUE_BITS-1:0] limit;
    logic [FRAC_BITS-1:0]  rpos;
    logic [FRAC_BITS-1:0]  rhgt;
  } item_t;

  typedef struct packed {
    logic                  busy;
    logic [VALUE_BITS-1:0] fe;
    logic [VALUE_BITS-1:0] bw;
    logic [TOP_BITS-1:0]   top;
  } geom_t;

  typedef logic [BIN_COUNT-1:0][OFF_BITS-1:0] edges_t;

endpackage

[design/histogram_rejection_sampler.sv]
// load transaction: handled while the sequencer is idle, no result
// draw transaction: steps MUL, CAND, CMP, ENC, LOOK, CENT, DONE; no new item is
// taken until the result leaves DONE; an empty span goes straight to DONE
// a 2-entry queue decouples input acceptance from execution
// synchronous reset clears the bin valid flags and peak; the edge table is
// then rebuilt with s_tready low, and again after every config write
`include "histogram_rejection_sampler_assert.svh"

module histogram_rejection_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hrs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hrs_pkg::VALUE_BITS-1:0]      cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // bin_index, bin_count, lower_limit, rand_position, rand_height, zero pad
  input  logic [hrs_pkg::S_TDATA_BITS-1:0]    s_tdata,
  // action
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // drawn_value, drawn_bin, zero pad
  output logic [hrs_pkg::M_TDATA_BITS-1:0]    m_tdata,
  // accepted
  output logic                                m_tuser
);

  hrs_pkg::geom_t   geom;
  hrs_pkg::edges_t  edges;
  hrs_pkg::item_t   q_item;
  logic             q_valid;
  logic             q_ready;

  hrs_edges u_edges (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .edges     (edges)
  );

  hrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .busy     (geom.busy),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  hrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .edges    (edges),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `HRS_ASSERT_IMP(a_no_accept_rebuild, clk, rst, s_tvalid && s_tready, !geom.busy)
  `HRS_ASSERT_NEXT(a_cfg_rebuilds, clk, rst, cfg_we, geom.busy)
  `HRS_ASSERT_IMP(a_reject_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0)

endmodule

[design/hrs_front.sv]
module hrs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // bin_index, bin_count, lower_limit, rand_position, rand_height, zero pad
  input  logic [hrs_pkg::S_TDATA_BITS-1:0]    s_tdata,
  // action
  input  logic                                s_tuser,
  input  logic                                busy,
  output logic                                q_valid,
  input  logic                                q_ready,
  output hrs_pkg::item_t                      q_item
);

  hrs_pkg::item_t                     item_in;
  hrs_pkg::item_t                     q_mem [hrs_pkg::QUEUE_DEPTH];
  logic [hrs_pkg::QPTR_BITS-1:0]      wptr;
  logic [hrs_pkg::QPTR_BITS-1:0]      rptr;
  logic [hrs_pkg::QPTR_BITS:0]        fill;
  logic                               keep;
  logic                               push;
  logic                               pop;

  always_comb begin
    item_in.kind  = hrs_pkg::kind_t'(s_tuser);
    item_in.idx   = s_tdata[5:0];
    item_in.cnt   = s_tdata[6 +: hrs_pkg::COUNT_BITS];
    item_in.limit = s_tdata[61:30];
    item_in.rpos  = s_tdata[93:62];
    item_in.rhgt  = s_tdata[125:94];
  end

  // loads outside the histogram are dropped here
  assign keep = (item_in.kind == hrs_pkg::KIND_DRAW) ||
                ({1'b0, item_in.idx} < (hrs_pkg::IDX_BITS+1)'(hrs_pkg::BIN_COUNT));

  assign s_tready = !busy && (fill != (hrs_pkg::QPTR_BITS+1)'(hrs_pkg::QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = fill != '0;
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wptr] <= item_in;
  end

endmodule

[design/hrs_edges.sv]
module hrs_edges (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hrs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hrs_pkg::VALUE_BITS-1:0]      cfg_data,
  output hrs_pkg::geom_t                      geom,
  output hrs_pkg::edges_t                     edges
);

  logic [hrs_pkg::VALUE_BITS-1:0]  fe;
  logic [hrs_pkg::VALUE_BITS-1:0]  bw;
  logic [hrs_pkg::TOP_BITS-1:0]    top;
  logic [hrs_pkg::SWEEP_BITS-1:0]  k;
  logic [hrs_pkg::OFF_BITS-1:0]    acc;
  hrs_pkg::edges_t                 edge_q;
  logic                            busy;

  assign busy = k != hrs_pkg::SWEEP_BITS'(hrs_pkg::BIN_COUNT + 1);

  assign geom.busy = busy;
  assign geom.fe   = fe;
  assign geom.bw   = bw;
  assign geom.top  = top;
  assign edges     = edge_q;

  // every write restarts the edge sweep: acc steps through i * bin_width
  always_ff @(posedge clk) begin
    if (rst) begin
      fe  <= '0;
      bw  <= hrs_pkg::VALUE_BITS'(1);
      k   <= '0;
      acc <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrs_pkg::REG_FIRST_EDGE: fe <= cfg_data;
        hrs_pkg::REG_BIN_WIDTH:  bw <= cfg_data;
        default: ;
      endcase
      k   <= '0;
      acc <= '0;
    end else if (busy) begin
      k   <= k + 1'b1;
      acc <= acc + hrs_pkg::OFF_BITS'(bw);
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_we && busy) begin
      if (k < hrs_pkg::SWEEP_BITS'(hrs_pkg::BIN_COUNT)) begin
        edge_q[k[hrs_pkg::IDX_BITS-1:0]] <= acc;
      end else begin
        top <= hrs_pkg::TOP_BITS'(fe) + hrs_pkg::TOP_BITS'(acc);
      end
    end
  end

endmodule

[design/hrs_back.sv]
module hrs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  hrs_pkg::geom_t                      geom,
  input  hrs_pkg::edges_t                     edges,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  hrs_pkg::item_t                      q_item,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // drawn_value, drawn_bin, zero pad
  output logic [hrs_pkg::M_TDATA_BITS-1:0]    m_tdata,
  // accepted
  output logic                                m_tuser
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_CAND = 8'b0000_0100,
    ST_CMP  = 8'b0000_1000,
    ST_ENC  = 8'b0001_0000,
    ST_LOOK = 8'b0010_0000,
    ST_CENT = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t                              state;
  hrs_pkg::item_t                      item;
  logic [hrs_pkg::COUNT_BITS-1:0]      counts [hrs_pkg::BIN_COUNT];
  logic [hrs_pkg::BIN_COUNT-1:0]       vld;
  logic [hrs_pkg::COUNT_BITS-1:0]      peak;
  logic [hrs_pkg::VALUE_BITS-1:0]      lo;
  logic [hrs_pkg::TOP_BITS-1:0]        span;
  logic [2*hrs_pkg::FRAC_BITS-1:0]     p_lo;
  logic [hrs_pkg::TOP_BITS-1:0]        p_hi;
  logic [hrs_pkg::HGT_BITS-1:0]        hgt;
  logic [hrs_pkg::TOP_BITS-1:0]        cand;
  logic [hrs_pkg::BIN_COUNT-1:0]       ge;
  logic [hrs_pkg::IDX_BITS-1:0]        bin;
  logic [hrs_pkg::COUNT_BITS-1:0]      rd_cnt;
  logic                                rd_vld;
  logic [hrs_pkg::OFF_BITS-1:0]        bin_off;
  logic                                acc_ok;
  logic                                res_acc;
  logic [hrs_pkg::VALUE_BITS-1:0]      res_value;
  logic [hrs_pkg::IDX_BITS-1:0]        res_bin;
  logic                                out_valid;
  logic                                out_acc;
  logic [hrs_pkg::VALUE_BITS-1:0]      out_value;
  logic [hrs_pkg::IDX_BITS-1:0]        out_bin;

  logic                                pop;
  logic                                load_we;
  logic [hrs_pkg::VALUE_BITS-1:0]      lo_next;
  logic                                empty;
  logic [hrs_pkg::TOP_BITS-1:0]        off;
  logic                                in_range;
  logic [hrs_pkg::BIN_COUNT-1:0]       ge_next;
  logic [hrs_pkg::BIN_COUNT-1:0]       ge_last;
  logic [hrs_pkg::IDX_BITS-1:0]        bin_enc;
  logic [hrs_pkg::COUNT_BITS-1:0]      cnt_eff;
  logic [hrs_pkg::TOP_BITS-1:0]        centre;
  logic                                out_free;

  assign q_ready  = state == ST_IDLE;
  assign pop      = q_valid && q_ready;
  assign load_we  = pop && (q_item.kind == hrs_pkg::KIND_LOAD);
  assign out_free = !out_valid || m_tready;

  assign lo_next = (q_item.limit > geom.fe) ? q_item.limit : geom.fe;
  assign empty   = (hrs_pkg::TOP_BITS'(lo_next) >= geom.top) || (geom.bw == '0);

  assign off      = cand - hrs_pkg::TOP_BITS'(geom.fe);
  assign in_range = (cand >= hrs_pkg::TOP_BITS'(geom.fe)) && (cand < geom.top);

  always_comb begin
    for (int i = 0; i < hrs_pkg::BIN_COUNT; i++) begin
      ge_next[i] = off >= hrs_pkg::TOP_BITS'(edges[i]);
    end
  end

  // highest edge at or below the candidate
  assign ge_last = ge & ~{1'b0, ge[hrs_pkg::BIN_COUNT-1:1]};

  always_comb begin
    bin_enc = '0;
    for (int i = 0; i < hrs_pkg::BIN_COUNT; i++) begin
      if (ge_last[i]) bin_enc = bin_enc | hrs_pkg::IDX_BITS'(i);
    end
  end

  assign cnt_eff = rd_vld ? rd_cnt : '0;
  assign centre  = hrs_pkg::TOP_BITS'(geom.fe) + hrs_pkg::TOP_BITS'(bin_off) +
                   hrs_pkg::TOP_BITS'(geom.bw[hrs_pkg::VALUE_BITS-1:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (q_item.kind == hrs_pkg::KIND_LOAD) begin
              vld[q_item.idx] <= 1'b1;
              if (q_item.cnt > peak) peak <= q_item.cnt;
            end else if (empty) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL:  state <= ST_CAND;
        ST_CAND: state <= ST_CMP;
        ST_CMP:  state <= in_range ? ST_ENC : ST_DONE;
        ST_ENC:  state <= ST_LOOK;
        ST_LOOK: state <= ST_CENT;
        ST_CENT: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item      <= q_item;
        lo        <= lo_next;
        span      <= geom.top - hrs_pkg::TOP_BITS'(lo_next);
        res_acc   <= 1'b0;
        res_value <= '0;
        res_bin   <= '0;
      end
      ST_MUL: begin
        p_lo <= (2*hrs_pkg::FRAC_BITS)'(item.rpos) *
                (2*hrs_pkg::FRAC_BITS)'(span[hrs_pkg::VALUE_BITS-1:0]);
        p_hi <= hrs_pkg::TOP_BITS'(item.rpos) *
                hrs_pkg::TOP_BITS'(span[hrs_pkg::TOP_BITS-1:hrs_pkg::VALUE_BITS]);
        hgt  <= hrs_pkg::HGT_BITS'(peak) * hrs_pkg::HGT_BITS'(item.rhgt);
      end
      ST_CAND: begin
        cand <= hrs_pkg::TOP_BITS'(lo) + p_hi +
                hrs_pkg::TOP_BITS'(p_lo[2*hrs_pkg::FRAC_BITS-1:hrs_pkg::FRAC_BITS]);
      end
      ST_CMP:  ge <= ge_next;
      ST_ENC: begin
        bin    <= bin_enc;
        rd_vld <= vld[bin_enc];
      end
      ST_LOOK: begin
        bin_off <= hrs_pkg::OFF_BITS'(bin) * hrs_pkg::OFF_BITS'(geom.bw);
        acc_ok  <= hgt <= {cnt_eff, {hrs_pkg::FRAC_BITS{1'b0}}};
      end
      ST_CENT: begin
        res_acc <= acc_ok;
        res_bin <= bin;
        if (!acc_ok) begin
          res_value <= '0;
        end else if (centre[hrs_pkg::TOP_BITS-1:hrs_pkg::VALUE_BITS] != '0) begin
          res_value <= '1;
        end else begin
          res_value <= centre[hrs_pkg::VALUE_BITS-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_acc   <= res_acc;
          out_value <= res_value;
          out_bin   <= res_bin;
        end
      end
      default: ;
    endcase
  end

  // count memory
  always_ff @(posedge clk) begin
    if (load_we) counts[q_item.idx] <= q_item.cnt;
    if (state == ST_ENC) rd_cnt <= counts[bin_enc];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{hrs_pkg::M_PAD_BITS{1'b0}}, out_bin, out_value};
  assign m_tuser  = out_acc;

endmodule
